### src/rgb_led_pulse_encoder_assert.svh
// Assertion macros used by the encoder core.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef RGB_LED_PULSE_ENCODER_ASSERT_SVH
`define RGB_LED_PULSE_ENCODER_ASSERT_SVH

// Condition a implies condition b at the same clock edge.
`define RGBPE_ASSERT_NOW(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
    else $error("rgbpe check failed");

// Condition a implies condition b at the following clock edge.
`define RGBPE_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
    else $error("rgbpe check failed");

`endif

### src/rgbpe_pkg.sv
package rgbpe_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int FRAME_W      = 3 * CHANNEL_BITS;
  localparam int BITS_W       = $clog2(FRAME_W + 1);
  localparam int SHORT_W      = 8;
  localparam int TICK_W       = 16;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_IDX_W    = CFG_ADDR_W - 2;

  // Request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_COLOR  = 2'd1;
  localparam logic [1:0] REQ_ENABLE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_GAP = 3'd4;

  // Register reset values
  localparam logic [SHORT_W-1:0] ONE_HIGH_RST  = 8'd16;
  localparam logic [SHORT_W-1:0] ONE_LOW_RST   = 8'd9;
  localparam logic [SHORT_W-1:0] ZERO_HIGH_RST = 8'd8;
  localparam logic [SHORT_W-1:0] ZERO_LOW_RST  = 8'd17;
  localparam logic [TICK_W-1:0]  LATCH_GAP_RST = 16'd1200;

  // Colour reset values
  localparam logic [CHANNEL_BITS-1:0] RED_RST   = '0;
  localparam logic [CHANNEL_BITS-1:0] GREEN_RST = '1;
  localparam logic [CHANNEL_BITS-1:0] BLUE_RST  = '0;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [SHORT_W-1:0] one_high_ticks;
    logic [SHORT_W-1:0] one_low_ticks;
    logic [SHORT_W-1:0] zero_high_ticks;
    logic [SHORT_W-1:0] zero_low_ticks;
    logic [TICK_W-1:0]  latch_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic                    enable_value;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } result_t;

  // A programmed length of zero counts as one tick.
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    logic [TICK_W-1:0] r;
    r = (v == '0) ? TICK_W'(1) : v;
    return r;
  endfunction

endpackage

### src/rgbpe_if.sv
interface rgbpe_in_if;
  import rgbpe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  logic                    enable_value;

  modport source (output valid, req_type, red, green, blue, enable_value, input ready);
  modport sink   (input valid, req_type, red, green, blue, enable_value, output ready);
endinterface

interface rgbpe_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, line_level, busy_res, frame_done, input ready);
  modport sink   (input valid, line_level, busy_res, frame_done, output ready);
endinterface

### src/rgbpe_cfg.sv
module rgbpe_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rgbpe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rgbpe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rgbpe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output rgbpe_pkg::cfg_t                 cfg
);
  import rgbpe_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_high_ticks  <= ONE_HIGH_RST;
      cfg_r.one_low_ticks   <= ONE_LOW_RST;
      cfg_r.zero_high_ticks <= ZERO_HIGH_RST;
      cfg_r.zero_low_ticks  <= ZERO_LOW_RST;
      cfg_r.latch_gap_ticks <= LATCH_GAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ONE_HIGH:  cfg_r.one_high_ticks  <= pwdata[SHORT_W-1:0];
        REG_ONE_LOW:   cfg_r.one_low_ticks   <= pwdata[SHORT_W-1:0];
        REG_ZERO_HIGH: cfg_r.zero_high_ticks <= pwdata[SHORT_W-1:0];
        REG_ZERO_LOW:  cfg_r.zero_low_ticks  <= pwdata[SHORT_W-1:0];
        REG_LATCH_GAP: cfg_r.latch_gap_ticks <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ONE_HIGH:  prdata = CFG_DATA_W'(cfg_r.one_high_ticks);
      REG_ONE_LOW:   prdata = CFG_DATA_W'(cfg_r.one_low_ticks);
      REG_ZERO_HIGH: prdata = CFG_DATA_W'(cfg_r.zero_high_ticks);
      REG_ZERO_LOW:  prdata = CFG_DATA_W'(cfg_r.zero_low_ticks);
      REG_LATCH_GAP: prdata = CFG_DATA_W'(cfg_r.latch_gap_ticks);
      default:       prdata = '0;
    endcase
  end

endmodule

### src/rgbpe_core.sv
module rgbpe_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  rgbpe_pkg::item_t   item,
  input  rgbpe_pkg::cfg_t    cfg,
  output rgbpe_pkg::result_t result
);
  import rgbpe_pkg::*;

  `include "rgb_led_pulse_encoder_assert.svh"

  logic [CHANNEL_BITS-1:0] red_r, red_nxt;
  logic [CHANNEL_BITS-1:0] green_r, green_nxt;
  logic [CHANNEL_BITS-1:0] blue_r, blue_nxt;
  logic                    enabled_r, enabled_nxt;
  logic                    pending_r, pending_nxt;
  logic [FRAME_W-1:0]      shift_r, shift_nxt;
  logic [BITS_W-1:0]       bits_r, bits_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [TICK_W-1:0]       ticks_r, ticks_nxt;

  logic                    start;
  logic                    done;
  logic [TICK_W-1:0]       ticks_dec;
  logic [FRAME_W-1:0]      shifted;
  logic [BITS_W-1:0]       bits_dec;

  assign ticks_dec = (ticks_r != '0) ? ticks_r - TICK_W'(1) : ticks_r;
  assign shifted   = {shift_r[FRAME_W-2:0], 1'b0};
  assign bits_dec  = (bits_r != '0) ? bits_r - BITS_W'(1) : bits_r;

  always_comb begin
    red_nxt     = red_r;
    green_nxt   = green_r;
    blue_nxt    = blue_r;
    enabled_nxt = enabled_r;
    pending_nxt = pending_r;
    shift_nxt   = shift_r;
    bits_nxt    = bits_r;
    phase_nxt   = phase_r;
    ticks_nxt   = ticks_r;
    start       = 1'b0;
    done        = 1'b0;

    unique case (item.req_type)
      REQ_TICK: begin
        if (phase_r != PH_IDLE) begin
          if (ticks_dec != '0) begin
            ticks_nxt = ticks_dec;
          end else begin
            unique case (phase_r)
              PH_HIGH: begin
                phase_nxt = PH_LOW;
                ticks_nxt = at_least_one(TICK_W'(shift_r[FRAME_W-1] ?
                                         cfg.one_low_ticks : cfg.zero_low_ticks));
              end
              PH_LOW: begin
                shift_nxt = shifted;
                bits_nxt  = bits_dec;
                if (bits_dec != '0) begin
                  phase_nxt = PH_HIGH;
                  ticks_nxt = at_least_one(TICK_W'(shifted[FRAME_W-1] ?
                                           cfg.one_high_ticks : cfg.zero_high_ticks));
                end else begin
                  phase_nxt = PH_GAP;
                  ticks_nxt = at_least_one(cfg.latch_gap_ticks);
                end
              end
              PH_GAP: begin
                done        = 1'b1;
                phase_nxt   = PH_IDLE;
                ticks_nxt   = '0;
                pending_nxt = 1'b0;
                start       = pending_r && enabled_r;
              end
              default: ;
            endcase
          end
        end
      end
      REQ_COLOR: begin
        red_nxt   = item.red;
        green_nxt = item.green;
        blue_nxt  = item.blue;
        if (enabled_r) begin
          if (phase_r == PH_IDLE) begin
            start = 1'b1;
          end else begin
            pending_nxt = 1'b1;
          end
        end
      end
      REQ_ENABLE: begin
        enabled_nxt = item.enable_value;
        if (item.enable_value) begin
          if (phase_r == PH_IDLE) begin
            start = 1'b1;
          end else begin
            pending_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // A new frame always carries the colour as it stands after this word.
    if (start) begin
      shift_nxt = {green_nxt, red_nxt, blue_nxt};
      bits_nxt  = BITS_W'(FRAME_W);
      phase_nxt = PH_HIGH;
      ticks_nxt = at_least_one(TICK_W'(green_nxt[CHANNEL_BITS-1] ?
                               cfg.one_high_ticks : cfg.zero_high_ticks));
    end
  end

  assign result.line_level = (phase_nxt == PH_HIGH);
  assign result.busy_res   = (phase_nxt != PH_IDLE);
  assign result.frame_done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r     <= RED_RST;
      green_r   <= GREEN_RST;
      blue_r    <= BLUE_RST;
      enabled_r <= 1'b1;
      pending_r <= 1'b0;
      shift_r   <= '0;
      bits_r    <= '0;
      phase_r   <= PH_IDLE;
      ticks_r   <= '0;
    end else if (step) begin
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      blue_r    <= blue_nxt;
      enabled_r <= enabled_nxt;
      pending_r <= pending_nxt;
      shift_r   <= shift_nxt;
      bits_r    <= bits_nxt;
      phase_r   <= phase_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  `RGBPE_ASSERT_NOW(a_bits_in_frame, (phase_r == PH_HIGH || phase_r == PH_LOW), (bits_r != '0))
  `RGBPE_ASSERT_NOW(a_ticks_when_busy, (phase_r != PH_IDLE), (ticks_r != '0))
  `RGBPE_ASSERT_NOW(a_no_pending_idle, (phase_r == PH_IDLE), (!pending_r))
  `RGBPE_ASSERT_NEXT(a_gap_end, (step && item.req_type == REQ_TICK && phase_r == PH_GAP && ticks_r == TICK_W'(1)), (phase_r == PH_IDLE || phase_r == PH_HIGH))

endmodule

### src/rgb_led_pulse_encoder.sv
// Single-wire RGB LED encoder. Each word on the input channel is a time tick, a set-colour
// request or a set-enable request, and each produces exactly one result word giving the data
// line level, a busy flag and a frame-done strobe. Waveform time is counted in tick words only:
// pulse and latch gap lengths are set through the register port and must be written only
// while idle; the block itself does not enforce this. A word passes through an input
// register and one step of the waveform state machine into the result register, so one word
// is taken every cycle when the result side is not stalled; the single state update per
// cycle sets that rate. After reset the colour is green at full intensity and the block is
// enabled, but no frame is sent until a request arrives.
module rgb_led_pulse_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  rgbpe_in_if.sink                         in_ch,
  rgbpe_out_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgbpe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rgbpe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rgbpe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import rgbpe_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    in_v_r, in_v_nxt;
  result_t res;
  result_t res_r;
  logic    out_v_r, out_v_nxt;
  logic    advance;
  logic    step;
  logic    in_fire;

  rgbpe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbpe_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg),
    .result (res)
  );

  // The result register frees up when empty or when its word is being taken.
  assign advance     = !out_v_r || out_ch.ready;
  assign step        = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_v_nxt  = in_fire ? 1'b1 : (step ? 1'b0 : in_v_r);
  assign out_v_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.req_type     <= in_ch.req_type;
      item_r.red          <= in_ch.red;
      item_r.green        <= in_ch.green;
      item_r.blue         <= in_ch.blue;
      item_r.enable_value <= in_ch.enable_value;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.line_level = res_r.line_level;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.frame_done = res_r.frame_done;

endmodule
